@@ rtl/ppft_pkg.sv @@
// Shared constants, register and operation codes, and the CORDIC arctangent
// values for the planar pose frame transform. No dependencies.
package ppft_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int ANGLE_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int ATAN_ENTRIES = 24;
    localparam int TRIG_W       = 34;
    localparam int Z_W          = 33;

    localparam logic [31:0] TRIG_GAIN_Q30 = 32'h26DD_3B6A;
    localparam logic signed [TRIG_W-1:0] TRIG_LIM = 34'sh0_4010_0000;

    localparam logic [2:0] OP_POINT_INV = 3'd0;
    localparam logic [2:0] OP_POINT_FWD = 3'd1;
    localparam logic [2:0] OP_TRANSLATE = 3'd2;
    localparam logic [2:0] OP_POSE_INV  = 3'd3;
    localparam logic [2:0] OP_POSE_FWD  = 3'd4;

    localparam logic [1:0] REG_FRAME_X     = 2'd0;
    localparam logic [1:0] REG_FRAME_Y     = 2'd1;
    localparam logic [1:0] REG_FRAME_ANGLE = 2'd2;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage

@@ rtl/planar_pose_frame_transform.sv @@
// Top level of the planar pose frame transform: frame registers, operand
// setup, the CORDIC cell chain and the product and output stages.
// Depends on ppft_pkg, ppft_cordic_cell, ppft_product and ppft_finish.

// Takes one word per clock while in_stall is low and returns one result word
// per input word, in order, after it has passed through every CORDIC cell,
// then the quadrant fold, split multiply, product sum and the clipped output
// register. Each cell holds one word, so a stall on the output backs the chain
// up only as far as it is full. Frame registers sit at byte addresses 0, 4
// and 8 (0, 8, 16 for coordinates wider than 32 bits) and must only be
// written while no word is in flight.
module planar_pose_frame_transform #(
    parameter int COORD_WIDTH   = ppft_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH   = ppft_pkg::ANGLE_WIDTH,
    parameter int CORDIC_STAGES = ppft_pkg::CORDIC_STAGES
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         psel,
    input  logic                                         penable,
    input  logic                                         pwrite,
    input  logic [((COORD_WIDTH > 32) ? 5 : 4)-1:0]      paddr,
    input  logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]    pwdata,
    output logic [((COORD_WIDTH > 32) ? 64 : 32)-1:0]    prdata,
    output logic                                         pready,
    input  logic                                         in_valid,
    output logic                                         in_stall,
    input  logic [2:0]                                   op,
    input  logic signed [COORD_WIDTH-1:0]                in_x,
    input  logic signed [COORD_WIDTH-1:0]                in_y,
    input  logic [ANGLE_WIDTH-1:0]                       in_angle,
    input  logic signed [COORD_WIDTH-1:0]                distance,
    output logic                                         out_valid,
    input  logic                                         out_stall,
    output logic signed [COORD_WIDTH-1:0]                out_x,
    output logic signed [COORD_WIDTH-1:0]                out_y,
    output logic [ANGLE_WIDTH-1:0]                       out_angle,
    output logic                                         saturated
);

    localparam int CFG_W    = (COORD_WIDTH > 32) ? 64 : 32;
    localparam int ADDR_W   = (COORD_WIDTH > 32) ? 5 : 4;
    localparam int ADDR_LSB = (COORD_WIDTH > 32) ? 3 : 2;
    localparam int TW       = ppft_pkg::TRIG_W;
    localparam int ZW       = ppft_pkg::Z_W;
    localparam int CW       = COORD_WIDTH;
    localparam int AW       = ANGLE_WIDTH;
    localparam int PW       = 2 + 1 + AW + 2 * (CW + 1) + 2 * CW;
    localparam int SW       = CW + 37;

    localparam logic signed [CW-1:0] MAX_C = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] MIN_C = {1'b1, {(CW-1){1'b0}}};

    logic [CW-1:0] frame_x_reg, frame_y_reg;
    logic [AW-1:0] frame_angle_reg;
    logic [ADDR_W-ADDR_LSB-1:0] reg_sel;

    // operand setup
    logic signed [CW:0]   px_e, py_e, fx_e, fy_e, dist_e, dx, dy;
    logic signed [CW:0]   u0, v0;
    logic signed [CW-1:0] tx0, ty0;
    logic        [AW-1:0] ang0;
    logic                 neg0;
    logic        [31:0]   ang32;
    logic        [PW-1:0] pay0;

    // cell chain
    logic signed [TW-1:0] cx   [0:CORDIC_STAGES];
    logic signed [TW-1:0] cy   [0:CORDIC_STAGES];
    logic signed [ZW-1:0] cz   [0:CORDIC_STAGES];
    logic        [PW-1:0] cpay [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] cvalid;
    logic [CORDIC_STAGES:0] cen;

    // chain tail fields
    logic        [1:0]    t_quad;
    logic                 t_neg;
    logic        [AW-1:0] t_ang;
    logic signed [CW:0]   t_u, t_v;
    logic signed [CW-1:0] t_tx, t_ty;

    logic                 p_valid, f_en;
    logic signed [SW-1:0] p_sum_x, p_sum_y;
    logic signed [CW-1:0] p_tx, p_ty;
    logic        [AW-1:0] p_ang;

    assign reg_sel = paddr[ADDR_W-1:ADDR_LSB];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_x_reg     <= '0;
            frame_y_reg     <= '0;
            frame_angle_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_sel)
                ppft_pkg::REG_FRAME_X:     frame_x_reg     <= pwdata[CW-1:0];
                ppft_pkg::REG_FRAME_Y:     frame_y_reg     <= pwdata[CW-1:0];
                ppft_pkg::REG_FRAME_ANGLE: frame_angle_reg <= pwdata[AW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            ppft_pkg::REG_FRAME_X:     prdata = CFG_W'(frame_x_reg);
            ppft_pkg::REG_FRAME_Y:     prdata = CFG_W'(frame_y_reg);
            ppft_pkg::REG_FRAME_ANGLE: prdata = CFG_W'(frame_angle_reg);
            default:                   prdata = '0;
        endcase
    end

    assign px_e   = (CW+1)'(in_x);
    assign py_e   = (CW+1)'(in_y);
    assign dist_e = (CW+1)'(distance);
    assign fx_e   = (CW+1)'($signed(frame_x_reg));
    assign fy_e   = (CW+1)'($signed(frame_y_reg));
    assign dx     = px_e - fx_e;
    assign dy     = py_e - fy_e;

    always_comb
    begin
        u0   = '0;
        v0   = '0;
        neg0 = 1'b0;
        tx0  = in_x;
        ty0  = in_y;
        ang0 = frame_angle_reg;
        case (op)
            ppft_pkg::OP_POINT_INV:
            begin
                u0  = dx;
                v0  = dy;
                tx0 = '0;
                ty0 = '0;
            end
            ppft_pkg::OP_POSE_INV:
            begin
                u0   = dx;
                v0   = dy;
                tx0  = '0;
                ty0  = '0;
                ang0 = in_angle - frame_angle_reg;
            end
            ppft_pkg::OP_POINT_FWD:
            begin
                u0   = px_e;
                v0   = py_e;
                neg0 = 1'b1;
                tx0  = $signed(frame_x_reg);
                ty0  = $signed(frame_y_reg);
            end
            ppft_pkg::OP_POSE_FWD:
            begin
                u0   = px_e;
                v0   = py_e;
                neg0 = 1'b1;
                tx0  = $signed(frame_x_reg);
                ty0  = $signed(frame_y_reg);
                ang0 = in_angle + frame_angle_reg;
            end
            ppft_pkg::OP_TRANSLATE:
            begin
                u0   = dist_e;
                neg0 = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign ang32 = {frame_angle_reg, {(32-AW){1'b0}}};
    assign pay0  = {ang32[31:30], neg0, ang0, u0, v0, tx0, ty0};

    assign cx[0]     = TW'(ppft_pkg::TRIG_GAIN_Q30);
    assign cy[0]     = '0;
    assign cz[0]     = $signed({3'b000, ang32[29:0]});
    assign cpay[0]   = pay0;
    assign cvalid[0] = in_valid;
    assign in_stall  = !cen[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++)
    begin : g_chain
        ppft_cordic_cell #(
            .IDX (k),
            .PW  (PW)
        ) u_rot (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (cvalid[k]),
            .up_en    (cen[k]),
            .x_in     (cx[k]),
            .y_in     (cy[k]),
            .z_in     (cz[k]),
            .pay_in   (cpay[k]),
            .valid    (cvalid[k+1]),
            .down_en  (cen[k+1]),
            .x_out    (cx[k+1]),
            .y_out    (cy[k+1]),
            .z_out    (cz[k+1]),
            .pay_out  (cpay[k+1])
        );
    end

    assign {t_quad, t_neg, t_ang, t_u, t_v, t_tx, t_ty} = cpay[CORDIC_STAGES];

    ppft_product #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_product (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (cvalid[CORDIC_STAGES]),
        .up_en    (cen[CORDIC_STAGES]),
        .quad_in  (t_quad),
        .neg_in   (t_neg),
        .ang_in   (t_ang),
        .u_in     (t_u),
        .v_in     (t_v),
        .tx_in    (t_tx),
        .ty_in    (t_ty),
        .x_in     (cx[CORDIC_STAGES]),
        .y_in     (cy[CORDIC_STAGES]),
        .valid    (p_valid),
        .down_en  (f_en),
        .sum_x    (p_sum_x),
        .sum_y    (p_sum_y),
        .tx       (p_tx),
        .ty       (p_ty),
        .ang      (p_ang)
    );

    ppft_finish #(
        .COORD_WIDTH (COORD_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (p_valid),
        .up_en     (f_en),
        .sum_x     (p_sum_x),
        .sum_y     (p_sum_y),
        .tx        (p_tx),
        .ty        (p_ty),
        .ang       (p_ang),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_angle (out_angle),
        .saturated (saturated)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> cvalid[1])
        else $error("accepted word did not enter the first cell");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && saturated) |-> (out_x == MAX_C || out_x == MIN_C
                                   || out_y == MAX_C || out_y == MIN_C))
        else $error("saturation flag without a clipped coordinate");

endmodule

@@ rtl/ppft_cordic_cell.sv @@
// One CORDIC rotation cell: a single micro-rotation plus the word payload it
// carries down the chain. Depends on ppft_pkg.
module ppft_cordic_cell #(
    parameter int IDX = 0,
    parameter int PW  = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_en,
    input  logic signed [ppft_pkg::TRIG_W-1:0] x_in,
    input  logic signed [ppft_pkg::TRIG_W-1:0] y_in,
    input  logic signed [ppft_pkg::Z_W-1:0]    z_in,
    input  logic        [PW-1:0]               pay_in,
    output logic                               valid,
    input  logic                               down_en,
    output logic signed [ppft_pkg::TRIG_W-1:0] x_out,
    output logic signed [ppft_pkg::TRIG_W-1:0] y_out,
    output logic signed [ppft_pkg::Z_W-1:0]    z_out,
    output logic        [PW-1:0]               pay_out
);

    localparam logic signed [ppft_pkg::Z_W-1:0] ATAN =
        $signed({1'b0, ppft_pkg::atan_turn(5'(IDX))});

    logic                               valid_reg;
    logic signed [ppft_pkg::TRIG_W-1:0] x_reg, y_reg, x_next, y_next, xs, ys;
    logic signed [ppft_pkg::Z_W-1:0]    z_reg, z_next;
    logic        [PW-1:0]               pay_reg;

    assign up_en = !valid_reg || down_en;

    assign xs = x_in >>> IDX;
    assign ys = y_in >>> IDX;

    always_comb
    begin
        if (!z_in[ppft_pkg::Z_W-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_en && up_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            pay_reg <= pay_in;
        end
    end

    assign valid   = valid_reg;
    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign pay_out = pay_reg;

endmodule

@@ rtl/ppft_product.sv @@
// Quadrant fold of the CORDIC result, split multiplies and the rounded
// product sums, as three pipeline stages. Depends on ppft_pkg.
module ppft_product #(
    parameter int COORD_WIDTH = ppft_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH = ppft_pkg::ANGLE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               up_valid,
    output logic                               up_en,
    input  logic        [1:0]                  quad_in,
    input  logic                               neg_in,
    input  logic        [ANGLE_WIDTH-1:0]      ang_in,
    input  logic signed [COORD_WIDTH:0]        u_in,
    input  logic signed [COORD_WIDTH:0]        v_in,
    input  logic signed [COORD_WIDTH-1:0]      tx_in,
    input  logic signed [COORD_WIDTH-1:0]      ty_in,
    input  logic signed [ppft_pkg::TRIG_W-1:0] x_in,
    input  logic signed [ppft_pkg::TRIG_W-1:0] y_in,
    output logic                               valid,
    input  logic                               down_en,
    output logic signed [COORD_WIDTH+36:0]     sum_x,
    output logic signed [COORD_WIDTH+36:0]     sum_y,
    output logic signed [COORD_WIDTH-1:0]      tx,
    output logic signed [COORD_WIDTH-1:0]      ty,
    output logic        [ANGLE_WIDTH-1:0]      ang
);

    localparam int TW   = ppft_pkg::TRIG_W;
    localparam int LO_W = 17 + TW;
    localparam int HI_W = COORD_WIDTH - 15 + TW;
    localparam int SW   = COORD_WIDTH + 37;
    localparam logic signed [SW-1:0] HALF = SW'(1) << 29;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    logic en_q, en_m, en_s;
    logic valid_q_reg, valid_m_reg, valid_s_reg;

    // quadrant stage
    logic signed [TW-1:0]          c_next, s_base, s_next;
    logic signed [TW-1:0]          c_q_reg, s_q_reg;
    logic signed [COORD_WIDTH:0]   u_q_reg, v_q_reg;
    logic signed [COORD_WIDTH-1:0] tx_q_reg, ty_q_reg;
    logic        [ANGLE_WIDTH-1:0] ang_q_reg;

    // multiply stage
    logic signed [COORD_WIDTH-16:0] u_hi, v_hi;
    logic signed [16:0]             u_lo, v_lo;
    logic signed [HI_W-1:0] uc_hi_next, vs_hi_next, vc_hi_next, us_hi_next;
    logic signed [LO_W-1:0] uc_lo_next, vs_lo_next, vc_lo_next, us_lo_next;
    logic signed [HI_W-1:0] uc_hi_reg, vs_hi_reg, vc_hi_reg, us_hi_reg;
    logic signed [LO_W-1:0] uc_lo_reg, vs_lo_reg, vc_lo_reg, us_lo_reg;
    logic signed [COORD_WIDTH-1:0] tx_m_reg, ty_m_reg;
    logic        [ANGLE_WIDTH-1:0] ang_m_reg;

    // sum stage
    logic signed [SW-1:0]          sum_x_next, sum_y_next, sum_x_reg, sum_y_reg;
    logic signed [COORD_WIDTH-1:0] tx_s_reg, ty_s_reg;
    logic        [ANGLE_WIDTH-1:0] ang_s_reg;

    assign en_s  = !valid_s_reg || down_en;
    assign en_m  = !valid_m_reg || en_s;
    assign en_q  = !valid_q_reg || en_m;
    assign up_en = en_q;

    always_comb
    begin
        case (quad_in)
            QUAD_FIRST:
            begin
                c_next = x_in;
                s_base = y_in;
            end
            QUAD_SECOND:
            begin
                c_next = -y_in;
                s_base = x_in;
            end
            QUAD_THIRD:
            begin
                c_next = -x_in;
                s_base = -y_in;
            end
            default:
            begin
                c_next = y_in;
                s_base = -x_in;
            end
        endcase
        s_next = neg_in ? -s_base : s_base;
    end

    assign u_hi = u_q_reg[COORD_WIDTH:16];
    assign v_hi = v_q_reg[COORD_WIDTH:16];
    assign u_lo = $signed({1'b0, u_q_reg[15:0]});
    assign v_lo = $signed({1'b0, v_q_reg[15:0]});

    assign uc_hi_next = u_hi * c_q_reg;
    assign uc_lo_next = u_lo * c_q_reg;
    assign vs_hi_next = v_hi * s_q_reg;
    assign vs_lo_next = v_lo * s_q_reg;
    assign vc_hi_next = v_hi * c_q_reg;
    assign vc_lo_next = v_lo * c_q_reg;
    assign us_hi_next = u_hi * s_q_reg;
    assign us_lo_next = u_lo * s_q_reg;

    assign sum_x_next = (SW'(uc_hi_reg) <<< 16) + SW'(uc_lo_reg)
                      + (SW'(vs_hi_reg) <<< 16) + SW'(vs_lo_reg) + HALF;
    assign sum_y_next = (SW'(vc_hi_reg) <<< 16) + SW'(vc_lo_reg)
                      - (SW'(us_hi_reg) <<< 16) - SW'(us_lo_reg) + HALF;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q_reg <= 1'b0;
            valid_m_reg <= 1'b0;
            valid_s_reg <= 1'b0;
        end
        else
        begin
            if (en_q)
            begin
                valid_q_reg <= up_valid;
            end
            if (en_m)
            begin
                valid_m_reg <= valid_q_reg;
            end
            if (en_s)
            begin
                valid_s_reg <= valid_m_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_q && up_valid)
        begin
            c_q_reg   <= c_next;
            s_q_reg   <= s_next;
            u_q_reg   <= u_in;
            v_q_reg   <= v_in;
            tx_q_reg  <= tx_in;
            ty_q_reg  <= ty_in;
            ang_q_reg <= ang_in;
        end
        if (en_m && valid_q_reg)
        begin
            uc_hi_reg <= uc_hi_next;
            uc_lo_reg <= uc_lo_next;
            vs_hi_reg <= vs_hi_next;
            vs_lo_reg <= vs_lo_next;
            vc_hi_reg <= vc_hi_next;
            vc_lo_reg <= vc_lo_next;
            us_hi_reg <= us_hi_next;
            us_lo_reg <= us_lo_next;
            tx_m_reg  <= tx_q_reg;
            ty_m_reg  <= ty_q_reg;
            ang_m_reg <= ang_q_reg;
        end
        if (en_s && valid_m_reg)
        begin
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            tx_s_reg  <= tx_m_reg;
            ty_s_reg  <= ty_m_reg;
            ang_s_reg <= ang_m_reg;
        end
    end

    assign valid = valid_s_reg;
    assign sum_x = sum_x_reg;
    assign sum_y = sum_y_reg;
    assign tx    = tx_s_reg;
    assign ty    = ty_s_reg;
    assign ang   = ang_s_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        valid_q_reg |-> (c_q_reg <= ppft_pkg::TRIG_LIM && c_q_reg >= -ppft_pkg::TRIG_LIM
                      && s_q_reg <= ppft_pkg::TRIG_LIM && s_q_reg >= -ppft_pkg::TRIG_LIM))
        else $error("trig value out of unit range");

endmodule

@@ rtl/ppft_finish.sv @@
// Final stage: scale the product sums, add the translation, clip to the
// coordinate range and hold the result word. Depends on ppft_pkg.
module ppft_finish #(
    parameter int COORD_WIDTH = ppft_pkg::COORD_WIDTH,
    parameter int ANGLE_WIDTH = ppft_pkg::ANGLE_WIDTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           up_valid,
    output logic                           up_en,
    input  logic signed [COORD_WIDTH+36:0] sum_x,
    input  logic signed [COORD_WIDTH+36:0] sum_y,
    input  logic signed [COORD_WIDTH-1:0]  tx,
    input  logic signed [COORD_WIDTH-1:0]  ty,
    input  logic        [ANGLE_WIDTH-1:0]  ang,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic signed [COORD_WIDTH-1:0]  out_x,
    output logic signed [COORD_WIDTH-1:0]  out_y,
    output logic        [ANGLE_WIDTH-1:0]  out_angle,
    output logic                           saturated
);

    localparam int RW = COORD_WIDTH + 8;
    localparam logic signed [RW-1:0] MAXV =
        {{(RW-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [RW-1:0] MINV =
        {{(RW-COORD_WIDTH+1){1'b1}}, {(COORD_WIDTH-1){1'b0}}};

    logic                          valid_reg;
    logic signed [RW-1:0]          rx, ry;
    logic signed [COORD_WIDTH-1:0] x_next, y_next, x_reg, y_reg;
    logic                          sat_x, sat_y;
    logic        [ANGLE_WIDTH-1:0] ang_reg;
    logic                          sat_reg;

    assign up_en = !valid_reg || !out_stall;

    assign rx = RW'(sum_x >>> 30) + RW'(tx);
    assign ry = RW'(sum_y >>> 30) + RW'(ty);

    always_comb
    begin
        sat_x = 1'b1;
        sat_y = 1'b1;
        if (rx > MAXV)
        begin
            x_next = MAXV[COORD_WIDTH-1:0];
        end
        else if (rx < MINV)
        begin
            x_next = MINV[COORD_WIDTH-1:0];
        end
        else
        begin
            x_next = rx[COORD_WIDTH-1:0];
            sat_x  = 1'b0;
        end
        if (ry > MAXV)
        begin
            y_next = MAXV[COORD_WIDTH-1:0];
        end
        else if (ry < MINV)
        begin
            y_next = MINV[COORD_WIDTH-1:0];
        end
        else
        begin
            y_next = ry[COORD_WIDTH-1:0];
            sat_y  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_en && up_valid)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            ang_reg <= ang;
            sat_reg <= sat_x || sat_y;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_angle = ang_reg;
    assign saturated = sat_reg;

endmodule

@@ tb/tb_planar_pose_frame_transform.sv @@
// Self-checking testbench for planar_pose_frame_transform: drives points and
// poses through the valid/stall channels and frames through the APB port.
// Depends on ppft_pkg and the RTL; a predictor class checks each output word.
`timescale 1ns / 1ps

typedef struct packed {
    logic [2:0]                             op;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] x;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] y;
    logic [ppft_pkg::ANGLE_WIDTH-1:0]       angle;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] travel;
} pose_word_t;

typedef struct packed {
    logic signed [ppft_pkg::COORD_WIDTH-1:0] x;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] y;
    logic [ppft_pkg::ANGLE_WIDTH-1:0]       angle;
    logic                                   sat;
} pose_result_t;

localparam longint ARCTAN_TURN [0:23] = '{
    64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4, 64'h028B_0D43,
    64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55, 64'h0028_BE53, 64'h0014_5F2F,
    64'h000A_2F98, 64'h0005_17CC, 64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA,
    64'h0000_517D, 64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
    64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051
};

class frame_pose_checker;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] frame_x;
    logic signed [ppft_pkg::COORD_WIDTH-1:0] frame_y;
    logic [ppft_pkg::ANGLE_WIDTH-1:0]       frame_angle;
    pose_result_t                           pending_poses[$];
    int                                     errors;

    function new();
        frame_x = '0;
        frame_y = '0;
        frame_angle = '0;
        errors = 0;
    endfunction

    function void set_frame(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            ppft_pkg::REG_FRAME_X:     frame_x = val;
            ppft_pkg::REG_FRAME_Y:     frame_y = val;
            ppft_pkg::REG_FRAME_ANGLE: frame_angle = val[ppft_pkg::ANGLE_WIDTH-1:0];
            default: ;
        endcase
    endfunction

    function void heading_trig(input logic [ppft_pkg::ANGLE_WIDTH-1:0] ang,
                               output longint c, output longint s);
        logic [31:0] u;
        longint      cx, cy, z, xs, ys;
        int          i;
        u = 32'(ang) << (32 - ppft_pkg::ANGLE_WIDTH);
        z = longint'(u[29:0]);
        cx = longint'(ppft_pkg::TRIG_GAIN_Q30);
        cy = 0;
        for (i = 0; i < ppft_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            xs = cx >>> i;
            ys = cy >>> i;
            if (z >= 0)
            begin
                cx = cx - ys;
                cy = cy + xs;
                z = z - ARCTAN_TURN[i];
            end
            else
            begin
                cx = cx + ys;
                cy = cy - xs;
                z = z + ARCTAN_TURN[i];
            end
        end
        case (u[31:30])
            2'd0:
            begin
                c = cx;
                s = cy;
            end
            2'd1:
            begin
                c = -cy;
                s = cx;
            end
            2'd2:
            begin
                c = -cx;
                s = -cy;
            end
            default:
            begin
                c = cy;
                s = -cx;
            end
        endcase
    endfunction

    // exact two-term dot product, rounded half up from Q30
    function longint dot_q30(input longint a1, input longint t1,
                             input longint a2, input longint t2);
        logic signed [127:0] w1, v1, w2, v2, acc;
        w1 = a1;
        v1 = t1;
        w2 = a2;
        v2 = t2;
        acc = w1 * v1 + w2 * v2 + 128'sh2000_0000;
        acc = acc >>> 30;
        return longint'(acc[63:0]);
    endfunction

    function logic [ppft_pkg::COORD_WIDTH-1:0] clip_coord(input longint v, inout bit sat);
        longint top, bottom;
        top = (64'sd1 <<< (ppft_pkg::COORD_WIDTH - 1)) - 1;
        bottom = -top - 1;
        if (v > top)
        begin
            sat = 1'b1;
            return top[ppft_pkg::COORD_WIDTH-1:0];
        end
        if (v < bottom)
        begin
            sat = 1'b1;
            return bottom[ppft_pkg::COORD_WIDTH-1:0];
        end
        return v[ppft_pkg::COORD_WIDTH-1:0];
    endfunction

    function void take_word(input pose_word_t w);
        longint       c, s, px, py, fx, fy, dx, dy, travel, rx, ry;
        pose_result_t r;
        bit           sat;
        heading_trig(frame_angle, c, s);
        px = $signed(w.x);
        py = $signed(w.y);
        fx = $signed(frame_x);
        fy = $signed(frame_y);
        travel = $signed(w.travel);
        sat = 1'b0;
        r.angle = frame_angle;
        case (w.op)
            ppft_pkg::OP_POINT_INV, ppft_pkg::OP_POSE_INV:
            begin
                dx = px - fx;
                dy = py - fy;
                rx = dot_q30(dx, c, dy, s);
                ry = dot_q30(dx, -s, dy, c);
                if (w.op == ppft_pkg::OP_POSE_INV)
                    r.angle = w.angle - frame_angle;
            end
            ppft_pkg::OP_POINT_FWD, ppft_pkg::OP_POSE_FWD:
            begin
                rx = dot_q30(px, c, py, -s) + fx;
                ry = dot_q30(px, s, py, c) + fy;
                if (w.op == ppft_pkg::OP_POSE_FWD)
                    r.angle = w.angle + frame_angle;
            end
            ppft_pkg::OP_TRANSLATE:
            begin
                rx = px + dot_q30(travel, c, 0, 0);
                ry = py + dot_q30(travel, s, 0, 0);
            end
            default:
            begin
                rx = px;
                ry = py;
            end
        endcase
        r.x = clip_coord(rx, sat);
        r.y = clip_coord(ry, sat);
        r.sat = sat;
        pending_poses.push_back(r);
    endfunction

    function void check_word(input pose_result_t got);
        pose_result_t want;
        if (pending_poses.size() == 0)
        begin
            $display("%0t: unexpected word x=%h y=%h angle=%h sat=%b",
                     $time, got.x, got.y, got.angle, got.sat);
            errors++;
            return;
        end
        want = pending_poses.pop_front();
        if (got.x !== want.x)
        begin
            $display("%0t: out_x expected %h actual %h", $time, want.x, got.x);
            errors++;
        end
        if (got.y !== want.y)
        begin
            $display("%0t: out_y expected %h actual %h", $time, want.y, got.y);
            errors++;
        end
        if (got.angle !== want.angle)
        begin
            $display("%0t: out_angle expected %h actual %h", $time, want.angle, got.angle);
            errors++;
        end
        if (got.sat !== want.sat)
        begin
            $display("%0t: saturated expected %b actual %b", $time, want.sat, got.sat);
            errors++;
        end
    endfunction

    function int pending();
        return pending_poses.size();
    endfunction
endclass

module tb_planar_pose_frame_transform;

    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 250;
    localparam int PHASE_WORDS = 150;
    localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN = 32'h8000_0000;

    logic                                     clk = 1'b0;
    logic                                     rst_n;
    logic                                     psel;
    logic                                     penable;
    logic                                     pwrite;
    logic [3:0]                               paddr;
    logic [31:0]                              pwdata;
    logic [31:0]                              prdata;
    logic                                     pready;
    logic                                     in_valid;
    logic                                     in_stall;
    logic [2:0]                               op;
    logic signed [ppft_pkg::COORD_WIDTH-1:0]  in_x;
    logic signed [ppft_pkg::COORD_WIDTH-1:0]  in_y;
    logic [ppft_pkg::ANGLE_WIDTH-1:0]         in_angle;
    logic signed [ppft_pkg::COORD_WIDTH-1:0]  distance;
    logic                                     out_valid;
    logic                                     out_stall;
    logic signed [ppft_pkg::COORD_WIDTH-1:0]  out_x;
    logic signed [ppft_pkg::COORD_WIDTH-1:0]  out_y;
    logic [ppft_pkg::ANGLE_WIDTH-1:0]         out_angle;
    logic                                     saturated;

    frame_pose_checker sb;
    int                quiet_cycles = 0;
    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;

    planar_pose_frame_transform u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .in_x      (in_x),
        .in_y      (in_y),
        .in_angle  (in_angle),
        .distance  (distance),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_angle (out_angle),
        .saturated (saturated)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.take_word({op, in_x, in_y, in_angle, distance});
            if (out_valid && !out_stall)
                sb.check_word({out_x, out_y, out_angle, saturated});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Test completed with failures");
        $finish;
    end

    // output side: random stalls, or a counted hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= idle_on && ($urandom_range(99) < 19);
        end
    end

    function automatic logic [31:0] rand_coord();
        logic [31:0] b;
        b = $urandom;
        case ($urandom_range(7))
            0, 1: return b;
            2:
            begin
                case (b[2:0])
                    3'd0: return C_MAX;
                    3'd1: return C_MIN;
                    3'd2: return 32'h0000_0000;
                    3'd3: return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            default: return {{8{b[23]}}, b[23:0]};
        endcase
    endfunction

    function automatic logic [2:0] rand_op();
        if ($urandom_range(19) < 2)
            return 3'($urandom_range(7, 5));
        return 3'($urandom_range(4, 0));
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        sb.set_frame(idx, val);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // drop valid and wait until the pipe is empty
    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (ppft_pkg::CORDIC_STAGES + 4)
            @(negedge clk);
    endtask

    task automatic load_frame(input logic [31:0] fx, input logic [31:0] fy,
                              input logic [15:0] fa);
        drain_pipe();
        write_reg(ppft_pkg::REG_FRAME_X, fx);
        write_reg(ppft_pkg::REG_FRAME_Y, fy);
        write_reg(ppft_pkg::REG_FRAME_ANGLE, {16'h0, fa});
    endtask

    // offer one word, hold it until accepted
    task automatic send_word(input logic [2:0] o, input logic [31:0] x, input logic [31:0] y,
                             input logic [15:0] a, input logic [31:0] d);
        while (idle_on && $urandom_range(99) < 19)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        in_x <= x;
        in_y <= y;
        in_angle <= a;
        distance <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        int          ph;
        int          n;
        logic [15:0] pick_angle;
        sb = new();
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = ppft_pkg::OP_POINT_INV;
        in_x = '0;
        in_y = '0;
        in_angle = '0;
        distance = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // frame at reset values
        send_word(ppft_pkg::OP_POINT_INV, C_MAX, C_MIN, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POINT_FWD, C_MIN, C_MAX, 16'hFFFF, C_MAX);
        send_word(3'd7, C_MAX, C_MIN, 16'hFFFF, C_MIN);

        load_frame(32'h0001_8000, 32'hFFFD_C000, 16'h2000);
        send_word(ppft_pkg::OP_POINT_INV, C_MIN, 32'h0003_0000, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POINT_FWD, C_MAX, C_MAX, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 16'h0000, C_MAX);
        send_word(ppft_pkg::OP_TRANSLATE, C_MIN, C_MIN, 16'h0000, C_MIN);
        send_word(ppft_pkg::OP_POSE_INV, 32'h0010_0000, 32'hFFF0_0000, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POSE_FWD, 32'hFFFF_0000, 32'h0001_0000, 16'hFFFF, 32'h0);
        send_word(3'd5, C_MIN, C_MAX, 16'h1234, C_MAX);
        send_word(3'd6, 32'h0000_0001, 32'hFFFF_FFFF, 16'h8000, 32'h1);

        load_frame(C_MAX, C_MIN, 16'hFFFF);
        send_word(ppft_pkg::OP_POINT_INV, C_MIN, C_MAX, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POINT_FWD, C_MAX, C_MIN, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POSE_INV, C_MAX, C_MAX, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POSE_FWD, C_MIN, C_MIN, 16'hFFFF, 32'h0);

        load_frame(32'h0000_0000, 32'h0000_0000, 16'h4000);
        send_word(ppft_pkg::OP_TRANSLATE, 32'h0001_0000, 32'h0001_0000, 16'h0000,
                  32'h0002_0000);
        send_word(ppft_pkg::OP_POSE_FWD, 32'h0001_0000, 32'h0000_0000, 16'hC000, 32'h0);
        load_frame(32'hFFFF_0000, 32'h0001_0000, 16'h8000);
        send_word(ppft_pkg::OP_POINT_FWD, 32'h0001_0000, 32'h0002_0000, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_TRANSLATE, 32'h0000_0000, 32'h0000_0000, 16'h0000, C_MAX);
        load_frame(32'h0000_8000, 32'hFFFF_8000, 16'hC000);
        send_word(ppft_pkg::OP_POINT_INV, 32'h0002_0000, 32'h0001_0000, 16'h0000, 32'h0);
        send_word(ppft_pkg::OP_POSE_INV, 32'h0000_0000, 32'h0000_0000, 16'h4000, 32'h0);

        for (ph = 0; ph < 6; ph++)
        begin
            pick_angle = 16'($urandom);
            case (ph)
                1: load_frame(C_MAX, C_MIN, 16'h8000);
                4: load_frame(C_MIN, C_MAX, 16'hFFFF);
                default: load_frame(rand_coord(), rand_coord(), pick_angle);
            endcase
            idle_on = (ph != 2);
            if (ph == 3)
                hold_req = 1'b1;
            for (n = 0; n < PHASE_WORDS; n++)
                send_word(rand_op(), rand_coord(), rand_coord(), 16'($urandom), rand_coord());
        end
        idle_on = 1'b1;

        drain_pipe();
        repeat (30)
            @(negedge clk);
        if (sb.pending() != 0)
            $display("%0t: %0d results never arrived", $time, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/ppft_pkg.sv
rtl/ppft_cordic_cell.sv
rtl/ppft_product.sv
rtl/ppft_finish.sv
rtl/planar_pose_frame_transform.sv
tb/tb_planar_pose_frame_transform.sv
